[hdl/rev_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the record envelope validator.
`timescale 1ns / 1ps
`default_nettype none

package rev_pkg;

  localparam int unsigned RECORD_BYTES_DEFAULT = 128;
  localparam logic [15:0] MAX_PAYLOAD          = 16'd112;
  localparam logic [15:0] LEGACY_MAX_PAYLOAD   = 16'd64;

  localparam logic [31:0] MAGIC_WORD     = 32'h5332_5042;
  localparam logic [31:0] CRC_POLY       = 32'hedb8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hffff_ffff;
  localparam int unsigned LEGACY_CRC_END = 76;
  localparam int unsigned HEADER_BYTES   = 12;

  localparam logic [15:0] SCHEMA_LEGACY  = 16'd1;
  localparam logic [15:0] SCHEMA_CURRENT = 16'd2;

  localparam int unsigned CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd112;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] ST_BAD_SCHEMA = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_BAD_CRC    = 3'd4;

  // Per-record header and CRC state carried from byte to byte.
  typedef struct packed {
    logic [31:0] running_crc;
    logic [31:0] captured_crc;
    logic [31:0] stored_crc;
    logic [31:0] magic;
    logic [15:0] schema;
    logic [15:0] length;
    logic [31:0] generation;
  } rec_state_t;

  // One result item.
  typedef struct packed {
    logic        legacy_format;
    logic [15:0] payload_length;
    logic [31:0] rec_gen;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        is_verdict;
  } rec_result_t;

  // Reflected CRC-32, one byte, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/record_envelope_validator.sv]
// Top level of the record envelope validator: state registers, config register, output skid.
//
//  channel   direction  tdata / data                     tuser / meaning
//  s_*       in         [7:0] record_byte                [0] start_of_record
//  m_*       out        [7:0] payload_byte, [10:8]       [0] is_verdict
//                       status, [42:11] generation,
//                       [58:43] length, [59] legacy
//  cfg_*     in         [6:0] buffer capacity            always ready
//
// One byte is taken per cycle while s_tready is high; the CRC byte update and the checks
// sit between the record state registers and the output register.
// The result of an accepted byte is registered in the output register, or in the skid entry while m_* is held.
// Reset clears the byte position, the valid flags and restores the capacity to 112.
// While m_tready is low, one more result can wait in the skid entry; s_tready drops
// only once that entry is full.
`timescale 1ns / 1ps
`default_nettype none

module record_envelope_validator #(
  parameter int unsigned RECORD_BYTES = rev_pkg::RECORD_BYTES_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,   // [7:0] record_byte
  input  wire logic                      s_tuser,   // [0] start_of_record
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [63:0]                    m_tdata,   // [7:0] payload_byte, [10:8] status,
                                                    // [42:11] generation,
                                                    // [58:43] payload_length,
                                                    // [59] legacy_format, rest zero
  output logic                           m_tuser,   // [0] is_verdict
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rev_pkg::CAP_W-1:0] cfg_data
);
  import rev_pkg::*;

  localparam int unsigned POS_W = $clog2(RECORD_BYTES);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  rec_state_t       state;
  rec_state_t       state_next;
  logic [CAP_W-1:0] capacity;
  logic             has_result;
  rec_result_t      result;
  rec_result_t      out_reg;
  rec_result_t      skid_reg;
  logic             skid_valid;
  logic             accept;
  logic             push;
  logic             pop;

  rev_step #(
    .RECORD_BYTES (RECORD_BYTES),
    .POS_W        (POS_W)
  ) u_step (
    .pos        (pos),
    .start      (s_tuser),
    .data       (s_tdata),
    .capacity   (capacity),
    .state      (state),
    .state_next (state_next),
    .pos_next   (pos_next),
    .has_result (has_result),
    .result     (result)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && has_result;
  assign pop       = m_tvalid && m_tready;

  assign m_tuser = out_reg.is_verdict;
  assign m_tdata = {4'd0, out_reg.legacy_format, out_reg.payload_length,
                    out_reg.rec_gen, out_reg.status, out_reg.payload_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // The running CRC is the top member of the state, so it takes the all-ones value.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      state <= {CRC_INIT, {($bits(rec_state_t) - 32){1'b0}}};
    end else if (accept) begin
      pos   <= pos_next;
      state <= state_next;
    end
  end

  // The skid entry only fills when a new result arrives while the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!m_tvalid || pop) begin
        out_reg  <= result;
        m_tvalid <= 1'b1;
      end else begin
        skid_reg   <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/rev_step.sv]
// Per-byte step logic: header capture, CRC update, payload pass-through and verdict.
`timescale 1ns / 1ps
`default_nettype none

module rev_step #(
  parameter int unsigned RECORD_BYTES = rev_pkg::RECORD_BYTES_DEFAULT,
  parameter int unsigned POS_W        = $clog2(RECORD_BYTES)
) (
  input  wire logic [POS_W-1:0]           pos,
  input  wire logic                       start,
  input  wire logic [7:0]                 data,
  input  wire logic [rev_pkg::CAP_W-1:0]  capacity,
  input  wire rev_pkg::rec_state_t        state,
  output rev_pkg::rec_state_t             state_next,
  output logic [POS_W-1:0]                pos_next,
  output logic                            has_result,
  output rev_pkg::rec_result_t            result
);
  import rev_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(RECORD_BYTES - 1);
  localparam logic [POS_W-1:0] CUR_END_M1  = POS_W'(RECORD_BYTES - 5);
  localparam logic [POS_W-1:0] CUR_BASE    = POS_W'(RECORD_BYTES - 4);
  localparam logic [POS_W-1:0] LEG_END_M1  = POS_W'(LEGACY_CRC_END - 1);
  localparam logic [POS_W-1:0] LEG_BASE    = POS_W'(LEGACY_CRC_END);
  localparam logic [POS_W-1:0] HDR_POS     = POS_W'(HEADER_BYTES);

  logic [POS_W-1:0] p;
  rec_state_t       s;
  logic [31:0]      crc_new;
  logic             legacy_sel;
  logic [POS_W-1:0] end_m1;
  logic [POS_W-1:0] base;
  logic [POS_W-1:0] stored_off;
  logic             is_last;
  logic             legacy;
  logic [15:0]      limit;
  logic [2:0]       status;
  logic [15:0]      payload_off;

  always_comb begin
    p = start ? '0 : pos;

    // Byte zero restarts the CRC and clears every captured field.
    if (p == '0) begin
      s = '0;
      s.running_crc = CRC_INIT;
    end else begin
      s = state;
    end

    if (p < POS_W'(4)) begin
      s.magic[{p[1:0], 3'b000} +: 8] = s.magic[{p[1:0], 3'b000} +: 8] | data;
    end else if (p < POS_W'(6)) begin
      s.schema[{p[0], 3'b000} +: 8] = s.schema[{p[0], 3'b000} +: 8] | data;
    end else if (p < POS_W'(8)) begin
      s.length[{p[0], 3'b000} +: 8] = s.length[{p[0], 3'b000} +: 8] | data;
    end else if (p < HDR_POS) begin
      s.generation[{p[1:0], 3'b000} +: 8] = s.generation[{p[1:0], 3'b000} +: 8] | data;
    end

    legacy_sel = (s.schema == SCHEMA_LEGACY) && (p >= POS_W'(6));
    end_m1     = legacy_sel ? LEG_END_M1 : CUR_END_M1;
    base       = legacy_sel ? LEG_BASE : CUR_BASE;

    crc_new       = crc_byte(s.running_crc, data);
    s.running_crc = crc_new;
    if (p == end_m1) begin
      s.captured_crc = ~crc_new;
    end
    // The offset form keeps the window test clear of wrap at the top of the position range.
    stored_off = p - base;
    if ((p >= base) && (stored_off < POS_W'(4))) begin
      s.stored_crc[{stored_off[1:0], 3'b000} +: 8] =
        s.stored_crc[{stored_off[1:0], 3'b000} +: 8] | data;
    end

    is_last = (p >= LAST_POS);
    legacy  = 1'b0;
    limit   = MAX_PAYLOAD;
    if (s.magic != MAGIC_WORD) begin
      status = ST_BAD_MAGIC;
    end else if ((s.schema != SCHEMA_CURRENT) && (s.schema != SCHEMA_LEGACY)) begin
      status = ST_BAD_SCHEMA;
    end else begin
      legacy = (s.schema == SCHEMA_LEGACY);
      limit  = legacy ? LEGACY_MAX_PAYLOAD : MAX_PAYLOAD;
      if ((s.length > limit) || (s.length > {{(16-CAP_W){1'b0}}, capacity})) begin
        status = ST_TOO_LONG;
      end else if (s.stored_crc != s.captured_crc) begin
        status = ST_BAD_CRC;
      end else begin
        status = ST_OK;
      end
    end

    payload_off = 16'(p) - 16'(HEADER_BYTES);

    result = '0;
    if (is_last) begin
      has_result            = 1'b1;
      result.is_verdict     = 1'b1;
      result.status         = status;
      result.rec_gen        = (status == ST_OK) ? s.generation : 32'd0;
      result.payload_length = (status == ST_OK) ? s.length : 16'd0;
      result.legacy_format  = legacy;
      pos_next              = '0;
    end else begin
      has_result          = (p >= HDR_POS) && (payload_off < s.length);
      result.payload_byte = data;
      pos_next            = p + POS_W'(1);
    end

    state_next = s;
  end

endmodule

`default_nettype wire

[tb/sv/record_envelope_validator_tb.sv]
// Self-checking testbench for the record envelope validator: record stimulus, predictor, checks.
`timescale 1ns / 1ps

module record_envelope_validator_tb;
  import rev_pkg::*;

  localparam int REC_LEN   = RECORD_BYTES_DEFAULT;
  localparam int HOLD_LEN  = 300;
  localparam int MAX_PRINT = 60;

  typedef enum int {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_SCHEMA,
    REC_TOO_LONG,
    REC_BAD_CRC,
    REC_NOISE
  } rec_kind_e;

  // Tracks the header and CRC of the record in flight and the results it must produce.
  class record_scoreboard;
    rec_result_t due_results[$];
    int unsigned errors;
    logic [6:0]  capacity;
    logic [7:0]  pos;
    logic [31:0] crc_run;
    logic [31:0] crc_final;
    logic [31:0] crc_stored;
    logic [31:0] magic;
    logic [15:0] schema;
    logic [15:0] len;
    logic [31:0] gen;

    function new();
      errors = 0;
      capacity = CAPACITY_RESET;
      pos = '0;
      crc_run = CRC_INIT;
      crc_final = '0;
      crc_stored = '0;
      magic = '0;
      schema = '0;
      len = '0;
      gen = '0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function void take_byte(logic [7:0] d, logic sof);
      int p;
      int crc_stop;
      int lim;
      rec_result_t r;
      if (sof) pos = '0;
      p = int'(pos);
      if (p == 0) begin
        crc_run = CRC_INIT;
        crc_final = '0;
        crc_stored = '0;
        magic = '0;
        schema = '0;
        len = '0;
        gen = '0;
      end
      if (p < 4) magic[8*p +: 8] = d;
      else if (p < 6) schema[8*(p-4) +: 8] = d;
      else if (p < 8) len[8*(p-6) +: 8] = d;
      else if (p < 12) gen[8*(p-8) +: 8] = d;

      // The legacy layout takes effect only once the whole schema word is in.
      crc_stop = (schema == SCHEMA_LEGACY && p >= 6) ? int'(LEGACY_CRC_END) : REC_LEN - 4;
      crc_run = crc_step(crc_run, d);
      if (p + 1 == crc_stop) crc_final = ~crc_run;
      if (p >= crc_stop && p < crc_stop + 4) crc_stored[8*(p-crc_stop) +: 8] = d;

      r = '0;
      if (p == REC_LEN - 1) begin
        pos = '0;
        r.is_verdict = 1'b1;
        if (magic != MAGIC_WORD) begin
          r.status = ST_BAD_MAGIC;
        end else if (schema != SCHEMA_CURRENT && schema != SCHEMA_LEGACY) begin
          r.status = ST_BAD_SCHEMA;
        end else begin
          r.legacy_format = (schema == SCHEMA_LEGACY);
          lim = r.legacy_format ? int'(LEGACY_MAX_PAYLOAD) : int'(MAX_PAYLOAD);
          if (int'(len) > lim || int'(len) > int'(capacity)) r.status = ST_TOO_LONG;
          else if (crc_stored != crc_final) r.status = ST_BAD_CRC;
          else r.status = ST_OK;
        end
        if (r.status == ST_OK) begin
          r.rec_gen = gen;
          r.payload_length = len;
        end
        due_results.push_back(r);
      end else begin
        pos = 8'(p + 1);
        if (p >= int'(HEADER_BYTES) && p - int'(HEADER_BYTES) < int'(len)) begin
          r.payload_byte = d;
          due_results.push_back(r);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINT) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_result(logic is_v, logic [63:0] word);
      rec_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result, tuser %b tdata 0x%016h", is_v, word));
        return;
      end
      want = due_results.pop_front();
      compare_field("is_verdict", 32'(is_v), 32'(want.is_verdict));
      compare_field("payload_byte", 32'(word[7:0]), 32'(want.payload_byte));
      compare_field("status", 32'(word[10:8]), 32'(want.status));
      compare_field("generation", word[42:11], want.rec_gen);
      compare_field("payload_length", 32'(word[58:43]), 32'(want.payload_length));
      compare_field("legacy_format", 32'(word[59]), 32'(want.legacy_format));
      compare_field("tdata padding", 32'(word[63:60]), 32'd0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  record_scoreboard sb;
  logic [7:0] rec_buf [0:REC_LEN-1];
  int burst_left;
  int items_sent;
  int hold_asks;

  record_envelope_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("record_envelope_validator_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Receiver: changes its stall pattern every so often and serves long hold-off requests.
  initial begin
    int mode;
    int mode_left;
    int tick;
    int hold_served;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_served = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asks) begin
        hold_served++;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = int'($urandom_range(0, 3));
          mode_left = int'($urandom_range(20, 150));
        end
        mode_left--;
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 4 != 3);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic sof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                               : int'($urandom_range(1, 40));
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tdata <= d;
    s_tuser <= sof;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_byte(d, sof);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_record(input int count, input logic sof0);
    for (int k = 0; k < count; k++) send_byte(rec_buf[k], (k == 0) ? sof0 : 1'b0);
  endtask

  // Sender stops and waits until every expected result has been taken.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.capacity = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fills rec_buf with one record; want_len below zero picks a length to suit the kind.
  task automatic build_record(input rec_kind_e kind, input bit legacy, input int want_len);
    int lim;
    int len;
    int crc_stop;
    int k;
    int bi;
    int bb;
    logic [31:0] c;
    logic [31:0] mg;
    logic [15:0] sch;
    for (k = 0; k < REC_LEN; k++) rec_buf[k] = 8'($urandom);
    if (kind == REC_NOISE) return;
    lim = legacy ? int'(LEGACY_MAX_PAYLOAD) : int'(MAX_PAYLOAD);
    if (int'(sb.capacity) < lim) lim = int'(sb.capacity);
    if (want_len >= 0) len = want_len;
    else if (kind == REC_TOO_LONG)
      len = ($urandom_range(0, 2) == 0) ? int'($urandom_range(lim + 1, 16'hffff))
                                        : lim + int'($urandom_range(1, 8));
    else len = int'($urandom_range(0, lim));
    sch = legacy ? SCHEMA_LEGACY : SCHEMA_CURRENT;
    if (kind == REC_BAD_SCHEMA) begin
      case ($urandom_range(0, 3))
        0: sch = 16'h0000;
        1: sch = 16'hffff;
        2: sch = 16'd3;
        default: begin
          sch = 16'($urandom);
          while (sch == SCHEMA_LEGACY || sch == SCHEMA_CURRENT) sch = 16'($urandom);
        end
      endcase
    end
    mg = MAGIC_WORD;
    if (kind == REC_BAD_MAGIC) begin
      bb = int'($urandom_range(0, 31));
      mg[bb] = ~mg[bb];
    end
    for (k = 0; k < 4; k++) rec_buf[k] = mg[8*k +: 8];
    rec_buf[4] = sch[7:0];
    rec_buf[5] = sch[15:8];
    rec_buf[6] = len[7:0];
    rec_buf[7] = len[15:8];
    crc_stop = legacy ? int'(LEGACY_CRC_END) : REC_LEN - 4;
    c = CRC_INIT;
    for (k = 0; k < crc_stop; k++) c = sb.crc_step(c, rec_buf[k]);
    c = ~c;
    for (k = 0; k < 4; k++) rec_buf[crc_stop + k] = c[8*k +: 8];
    // Corrupt the generation, the payload, the bytes after it or the stored CRC itself.
    if (kind == REC_BAD_CRC) begin
      bi = int'($urandom_range(8, crc_stop + 3));
      bb = int'($urandom_range(0, 7));
      rec_buf[bi][bb] = ~rec_buf[bi][bb];
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst_left = 0;
    items_sent = 0;
    hold_asks = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Records at the reset capacity.
    build_record(REC_GOOD, 1'b0, int'(MAX_PAYLOAD));
    send_record(REC_LEN, 1'b1);
    // No start mark: the position wraps on its own after a full record.
    build_record(REC_GOOD, 1'b1, int'(LEGACY_MAX_PAYLOAD));
    send_record(REC_LEN, 1'b0);
    build_record(REC_BAD_MAGIC, 1'b0, -1);
    send_record(REC_LEN, 1'b0);
    // A record cut short and dropped by the start mark of the next one.
    build_record(REC_GOOD, 1'b0, 40);
    send_record(20, 1'b0);
    build_record(REC_BAD_SCHEMA, 1'b0, -1);
    send_record(REC_LEN, 1'b1);

    // Capacity below the schema limit, while the receiver holds off for a long stretch.
    write_capacity(7'd64);
    hold_asks++;
    build_record(REC_TOO_LONG, 1'b0, int'(LEGACY_MAX_PAYLOAD) + 1);
    send_record(REC_LEN, 1'b0);

    // Capacity above the schema limits.
    write_capacity(7'd127);
    build_record(REC_BAD_CRC, 1'b1, -1);
    send_record(REC_LEN, 1'b0);

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("record_envelope_validator_tb: done, clean");
    end else begin
      $display("record_envelope_validator_tb: done, errors");
    end
    $finish;
  end

endmodule
